// ===== rtl/ndg_pkg.sv =====
// Shared types, widths and note constants for the greedy note dispenser.
// Used by note_dispenser_greedy_core; depends on nothing else.
`default_nettype none

package ndg_pkg;

    localparam int COUNT_WIDTH  = 16;
    localparam int AMOUNT_WIDTH = 24;
    localparam int NUM_NOTES    = 5;
    localparam int IDX_W        = $clog2(NUM_NOTES);
    localparam int NOTE_W       = 7;

    // stream widths, padded to whole bytes
    localparam int S_RAW_W  = AMOUNT_WIDTH + NUM_NOTES * COUNT_WIDTH;
    localparam int S_DATA_W = ((S_RAW_W + 7) / 8) * 8;
    localparam int M_RAW_W  = 2 * NUM_NOTES * COUNT_WIDTH;
    localparam int M_DATA_W = ((M_RAW_W + 7) / 8) * 8;

    localparam logic [NOTE_W-1:0] NOTE_HUNDRED = NOTE_W'(100);
    localparam logic [NOTE_W-1:0] NOTE_FIFTY   = NOTE_W'(50);
    localparam logic [NOTE_W-1:0] NOTE_TEN     = NOTE_W'(10);
    localparam logic [NOTE_W-1:0] NOTE_FIVE    = NOTE_W'(5);
    localparam logic [NOTE_W-1:0] NOTE_ONE     = NOTE_W'(1);

    // floor(2^AMOUNT_WIDTH / value); the quotient estimate is exact or one short
    localparam int RECIP_W = AMOUNT_WIDTH + 1;
    localparam logic [RECIP_W-1:0] RECIP_HUNDRED = RECIP_W'((65'd1 << AMOUNT_WIDTH) / 100);
    localparam logic [RECIP_W-1:0] RECIP_FIFTY   = RECIP_W'((65'd1 << AMOUNT_WIDTH) / 50);
    localparam logic [RECIP_W-1:0] RECIP_TEN     = RECIP_W'((65'd1 << AMOUNT_WIDTH) / 10);
    localparam logic [RECIP_W-1:0] RECIP_FIVE    = RECIP_W'((65'd1 << AMOUNT_WIDTH) / 5);
    localparam logic [RECIP_W-1:0] RECIP_ONE     = RECIP_W'(65'd1 << AMOUNT_WIDTH);

    localparam logic REQ_WITHDRAW = 1'b0;
    localparam logic REQ_DEPOSIT  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_EST,
        ST_COR,
        ST_TAKE,
        ST_FIN
    } ndg_state_t;

    function automatic logic [NOTE_W-1:0] note_value(input logic [IDX_W-1:0] idx);
        logic [NOTE_W-1:0] v;
        case (idx)
            IDX_W'(0): v = NOTE_HUNDRED;
            IDX_W'(1): v = NOTE_FIFTY;
            IDX_W'(2): v = NOTE_TEN;
            IDX_W'(3): v = NOTE_FIVE;
            default:   v = NOTE_ONE;
        endcase
        return v;
    endfunction

    function automatic logic [RECIP_W-1:0] note_recip(input logic [IDX_W-1:0] idx);
        logic [RECIP_W-1:0] r;
        case (idx)
            IDX_W'(0): r = RECIP_HUNDRED;
            IDX_W'(1): r = RECIP_FIFTY;
            IDX_W'(2): r = RECIP_TEN;
            IDX_W'(3): r = RECIP_FIVE;
            default:   r = RECIP_ONE;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/note_dispenser_greedy_core.sv =====
// Greedy note dispenser with limited stock: stream in, stream out.
// Depends on ndg_pkg (widths, note constants, state type).
//
// A deposit request adds five note counts (saturating) and goes straight to the final
// step. A withdrawal walks the note values largest first on one shared reciprocal
// multiplier (quotient estimate, back-multiply, one-step correction, clamp to stock).
// The final step registers the result of either kind, and a new request is taken only
// once the core is back in idle, so the input side stays low while a request is in
// work. A finished result sits in the output register; if it has not been taken, the
// next result waits in its final step. A failed withdrawal returns zero paid counts
// and leaves stock as is.
`default_nettype none

module note_dispenser_greedy_core
    import ndg_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // amount, add_hundreds, add_fifties, add_tens, add_fives, add_ones
    input  wire logic [S_DATA_W-1:0]  s_axis_tdata,
    // req_type
    input  wire logic                 s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // out_hundreds .. out_ones, left_hundreds .. left_ones
    output logic [M_DATA_W-1:0]       m_axis_tdata,
    // success
    output logic                      m_axis_tuser
);

    localparam int PROD_W   = AMOUNT_WIDTH + RECIP_W;
    localparam int QV_W     = AMOUNT_WIDTH + NOTE_W;
    localparam int SV_W     = COUNT_WIDTH + NOTE_W;
    localparam int WIDE_W   = (AMOUNT_WIDTH > SV_W) ? AMOUNT_WIDTH : SV_W;
    localparam int CMP_W    = (AMOUNT_WIDTH > COUNT_WIDTH) ? AMOUNT_WIDTH : COUNT_WIDTH;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_NOTES - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    ndg_state_t state_reg, state_next;

    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    m_valid_reg, m_valid_next;
    logic [COUNT_WIDTH-1:0]  stock_reg [NUM_NOTES];
    logic [COUNT_WIDTH-1:0]  stock_next [NUM_NOTES];

    logic                    req_reg, req_next;
    logic [AMOUNT_WIDTH-1:0] rest_reg, rest_next;
    logic [AMOUNT_WIDTH-1:0] rem_reg, rem_next;
    logic [AMOUNT_WIDTH-1:0] q_reg, q_next;
    logic [AMOUNT_WIDTH-1:0] qv_reg, qv_next;
    logic [SV_W-1:0]         sv_reg, sv_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [COUNT_WIDTH-1:0]  add_reg [NUM_NOTES];
    logic [COUNT_WIDTH-1:0]  add_next [NUM_NOTES];
    logic [COUNT_WIDTH-1:0]  taken_reg [NUM_NOTES];
    logic [COUNT_WIDTH-1:0]  taken_next [NUM_NOTES];
    logic                    success_reg, success_next;
    logic [M_RAW_W-1:0]      res_reg, res_next;

    logic                    accept;
    logic                    fin_fire;
    logic [NOTE_W-1:0]       nv;
    logic [COUNT_WIDTH-1:0]  stock_cur;
    logic [AMOUNT_WIDTH-1:0] q_est;
    logic [QV_W-1:0]         qv_full;
    logic [AMOUNT_WIDTH-1:0] rem;
    logic [COUNT_WIDTH:0]    dep_sum;
    logic [COUNT_WIDTH-1:0]  new_stock;
    logic                    served;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = (s_axis_tuser == REQ_DEPOSIT) ? ST_FIN : ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_EST;
            ST_EST:  state_next = ST_COR;
            ST_COR:  state_next = ST_TAKE;
            ST_TAKE: state_next = (idx_reg == LAST_IDX) ? ST_FIN : ST_MUL;
            ST_FIN:
            begin
                if (fin_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        accept        = s_axis_tvalid && (state_reg == ST_IDLE);
        fin_fire      = (state_reg == ST_FIN) && (!m_valid_reg || m_axis_tready);
        m_axis_tvalid = m_valid_reg;
        m_axis_tuser  = success_reg;
        m_axis_tdata  = M_DATA_W'(res_reg);
    end

    // ---------------- datapath ----------------
    always_comb
    begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        req_next     = req_reg;
        rest_next    = rest_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;
        qv_next      = qv_reg;
        sv_next      = sv_reg;
        prod_next    = prod_reg;
        success_next = success_reg;
        res_next     = res_reg;
        stock_next   = stock_reg;
        add_next     = add_reg;
        taken_next   = taken_reg;

        nv        = note_value(idx_reg);
        stock_cur = stock_reg[idx_reg];
        q_est     = prod_reg[2*AMOUNT_WIDTH-1:AMOUNT_WIDTH];
        qv_full   = QV_W'(q_est) * QV_W'(nv);
        rem       = rest_reg - qv_reg;
        served    = (rest_reg == '0);
        dep_sum   = '0;
        new_stock = '0;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next  = s_axis_tuser;
                    rest_next = s_axis_tdata[AMOUNT_WIDTH-1:0];
                    idx_next  = '0;
                    for (int i = 0; i < NUM_NOTES; i++)
                    begin
                        add_next[i] = s_axis_tdata[AMOUNT_WIDTH + i*COUNT_WIDTH +: COUNT_WIDTH];
                    end
                end
            end
            ST_MUL:
            begin
                prod_next = PROD_W'(rest_reg) * PROD_W'(note_recip(idx_reg));
            end
            ST_EST:
            begin
                q_next  = q_est;
                qv_next = qv_full[AMOUNT_WIDTH-1:0];
                sv_next = SV_W'(stock_cur) * SV_W'(nv);
            end
            ST_COR:
            begin
                // estimate may be one short
                if (rem >= AMOUNT_WIDTH'(nv))
                begin
                    q_next   = q_reg + AMOUNT_WIDTH'(1);
                    rem_next = rem - AMOUNT_WIDTH'(nv);
                end
                else
                begin
                    rem_next = rem;
                end
            end
            ST_TAKE:
            begin
                if (CMP_W'(q_reg) <= CMP_W'(stock_cur))
                begin
                    taken_next[idx_reg] = COUNT_WIDTH'(q_reg);
                    rest_next           = rem_reg;
                end
                else
                begin
                    taken_next[idx_reg] = stock_cur;
                    rest_next = AMOUNT_WIDTH'(WIDE_W'(rest_reg) - WIDE_W'(sv_reg));
                end
                if (idx_reg != LAST_IDX)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_FIN:
            begin
                if (fin_fire)
                begin
                    m_valid_next = 1'b1;
                    success_next = (req_reg == REQ_DEPOSIT) || served;
                    for (int i = 0; i < NUM_NOTES; i++)
                    begin
                        if (req_reg == REQ_DEPOSIT)
                        begin
                            dep_sum   = {1'b0, stock_reg[i]} + {1'b0, add_reg[i]};
                            new_stock = dep_sum[COUNT_WIDTH] ? COUNT_MAX
                                                             : dep_sum[COUNT_WIDTH-1:0];
                            res_next[i*COUNT_WIDTH +: COUNT_WIDTH] = '0;
                        end
                        else if (served)
                        begin
                            new_stock = stock_reg[i] - taken_reg[i];
                            res_next[i*COUNT_WIDTH +: COUNT_WIDTH] = taken_reg[i];
                        end
                        else
                        begin
                            new_stock = stock_reg[i];
                            res_next[i*COUNT_WIDTH +: COUNT_WIDTH] = '0;
                        end
                        stock_next[i] = new_stock;
                        res_next[(NUM_NOTES + i)*COUNT_WIDTH +: COUNT_WIDTH] = new_stock;
                    end
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_NOTES; i++)
            begin
                stock_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
            stock_reg   <= stock_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        rest_reg    <= rest_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        qv_reg      <= qv_next;
        sv_reg      <= sv_next;
        prod_reg    <= prod_next;
        success_reg <= success_next;
        res_reg     <= res_next;
        add_reg     <= add_next;
        taken_reg   <= taken_next;
    end

    // ---------------- assertions ----------------
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (idx_reg <= LAST_IDX))
        else $error("note index out of range");

    a_take_le_stock: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAKE) |=> (taken_reg[$past(idx_reg)] <= stock_reg[$past(idx_reg)]))
        else $error("dispensed more notes than in stock");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !success_reg) |-> (res_reg[NUM_NOTES*COUNT_WIDTH-1:0] == '0))
        else $error("failed withdrawal reports dispensed notes");

    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_axis_tuser == REQ_WITHDRAW)) |=> (state_reg == ST_MUL && !s_axis_tready))
        else $error("withdrawal did not start the note walk");

endmodule

`default_nettype wire

// ===== verif/note_dispenser_greedy_core_test.sv =====
// Self-checking testbench for note_dispenser_greedy_core: a directed table, then random requests.
// Each receipt is checked against its typed table row, else a greedy payout predictor kept in step with the stock.
// Depends on ndg_pkg and the core RTL only.

module note_dispenser_greedy_core_test;

    import ndg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int REQ_DATA_W   = AMOUNT_WIDTH + NUM_NOTES * COUNT_WIDTH;
    localparam int RES_DATA_W   = 2 * NUM_NOTES * COUNT_WIDTH;
    localparam int RANDOM_ITEMS = 1100;
    localparam int IDLE_PCT     = 18;
    localparam int CALM_FROM    = 600;    // stretch of requests with no idling on either side
    localparam int CALM_TO      = 800;
    localparam int PRESSURE_AT  = 300;    // receipts seen before the long hold-off
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 40;
    localparam int MAX_REPORTS  = 40;

    localparam logic [COUNT_WIDTH-1:0] COUNT_FULL = '1;

    typedef logic [NUM_NOTES-1:0][COUNT_WIDTH-1:0] note_counts_t;   // index 0 = hundreds

    typedef struct packed {
        logic                    req_type;
        logic [AMOUNT_WIDTH-1:0] amount;
        note_counts_t            add;
    } dispense_req_t;

    typedef struct packed {
        logic         success;
        note_counts_t paid;
        note_counts_t left;
    } receipt_t;

    typedef struct {
        dispense_req_t req;
        bit            typed;
        receipt_t      res;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [REQ_DATA_W-1:0] s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [RES_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    note_dispenser_greedy_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    const int unsigned note_val[NUM_NOTES] = '{100, 50, 10, 5, 1};
    const string note_name[NUM_NOTES] = '{"hundreds", "fifties", "tens", "fives", "ones"};

    logic [COUNT_WIDTH-1:0] model_stock[NUM_NOTES];
    receipt_t  due_receipts[$];
    stim_row_t dir_table[$];
    int        errors;
    int        reports;
    int        receipts_seen;
    int        hold_left;
    int        req_index;
    int        stall_count;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic dispense_req_t make_req(input logic kind, input logic [AMOUNT_WIDTH-1:0] amt,
                                               input note_counts_t counts);
        dispense_req_t r;
        r.req_type = kind;
        r.amount   = amt;
        r.add      = counts;
        return r;
    endfunction

    function automatic note_counts_t all_counts(input logic [COUNT_WIDTH-1:0] v);
        note_counts_t c;
        for (int i = 0; i < NUM_NOTES; i++)
            c[i] = v;
        return c;
    endfunction

    function automatic receipt_t uniform_receipt(input logic ok, input logic [COUNT_WIDTH-1:0] paid,
                                                 input logic [COUNT_WIDTH-1:0] left);
        receipt_t r;
        r.success = ok;
        r.paid    = all_counts(paid);
        r.left    = all_counts(left);
        return r;
    endfunction

    // Greedy payout against the model stock; stock moves only on success or deposit.
    function automatic receipt_t serve_request(input dispense_req_t r);
        receipt_t        res;
        longint unsigned rest;
        longint unsigned want;
        longint unsigned take;
        longint unsigned sum;
        res.success = 1'b1;
        res.paid    = '0;
        if (r.req_type == REQ_WITHDRAW)
        begin
            rest = r.amount;
            for (int i = 0; i < NUM_NOTES; i++)
            begin
                want = rest / note_val[i];
                take = (want < model_stock[i]) ? want : model_stock[i];
                res.paid[i] = COUNT_WIDTH'(take);
                rest = rest - take * note_val[i];
            end
            if (rest != 0)
            begin
                res.success = 1'b0;
                res.paid    = '0;
            end
            else
            begin
                for (int i = 0; i < NUM_NOTES; i++)
                    model_stock[i] = model_stock[i] - res.paid[i];
            end
        end
        else
        begin
            for (int i = 0; i < NUM_NOTES; i++)
            begin
                sum = longint'(model_stock[i]) + r.add[i];
                model_stock[i] = (sum > COUNT_FULL) ? COUNT_FULL : COUNT_WIDTH'(sum);
            end
        end
        for (int i = 0; i < NUM_NOTES; i++)
            res.left[i] = model_stock[i];
        return res;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] random_count();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 6)
            return COUNT_WIDTH'($urandom_range(40));
        else if (sel < 8)
            return COUNT_WIDTH'($urandom_range(2000));
        else if (sel == 8)
            return COUNT_WIDTH'($urandom());
        return COUNT_FULL;
    endfunction

    function automatic dispense_req_t random_req();
        note_counts_t            counts;
        logic [AMOUNT_WIDTH-1:0] amt;
        int unsigned             sel;
        if ($urandom_range(99) < 35)
        begin
            for (int i = 0; i < NUM_NOTES; i++)
                counts[i] = random_count();
            return make_req(REQ_DEPOSIT, AMOUNT_WIDTH'($urandom()), counts);
        end
        for (int i = 0; i < NUM_NOTES; i++)
            counts[i] = COUNT_WIDTH'($urandom());
        sel = $urandom_range(9);
        if (sel < 6)
            amt = AMOUNT_WIDTH'($urandom_range(3000));
        else if (sel < 8)
            amt = AMOUNT_WIDTH'($urandom_range(200000));
        else
            amt = AMOUNT_WIDTH'($urandom());
        return make_req(REQ_WITHDRAW, amt, counts);
    endfunction

    // Offer one request, hold it until taken, then log what the receipt must be.
    task automatic offer_request(input dispense_req_t r, input bit typed, input receipt_t typed_res);
        receipt_t pred;
        int       idle;
        idle = (req_index >= CALM_FROM && req_index < CALM_TO) ? 0 : IDLE_PCT;
        while ($urandom_range(99) < idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.add, r.amount};
        s_axis_tuser  <= r.req_type;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pred = serve_request(r);
        due_receipts.push_back(typed ? typed_res : pred);
        req_index++;
    endtask

    task automatic check_receipt(input logic [RES_DATA_W-1:0] data, input logic ok);
        receipt_t want;
        receipt_t got;
        if (due_receipts.size() == 0)
        begin
            errors++;
            if (reports++ < MAX_REPORTS)
                $display("%0t: receipt with no request outstanding: %h / %b", $time, data, ok);
            return;
        end
        want = due_receipts.pop_front();
        got.success = ok;
        {got.left, got.paid} = data;
        if (got.success !== want.success)
        begin
            errors++;
            if (reports++ < MAX_REPORTS)
                $display("%0t: success expected %b actual %b", $time, want.success, got.success);
        end
        for (int i = 0; i < NUM_NOTES; i++)
        begin
            if (got.paid[i] !== want.paid[i])
            begin
                errors++;
                if (reports++ < MAX_REPORTS)
                    $display("%0t: out_%s expected %0d actual %0d", $time, note_name[i],
                             want.paid[i], got.paid[i]);
            end
            if (got.left[i] !== want.left[i])
            begin
                errors++;
                if (reports++ < MAX_REPORTS)
                    $display("%0t: left_%s expected %0d actual %0d", $time, note_name[i],
                             want.left[i], got.left[i]);
            end
        end
    endtask

    // Receiver: takes receipts, stalls at random, and once holds off long enough to fill the core.
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            check_receipt(m_axis_tdata, m_axis_tuser);
            receipts_seen = receipts_seen + 1;
            if (receipts_seen == PRESSURE_AT)
                hold_left = HOLD_CYCLES;
        end
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (receipts_seen >= CALM_FROM && receipts_seen < CALM_TO)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_count = 0;
        else
            stall_count = stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        errors        = 0;
        reports       = 0;
        receipts_seen = 0;
        hold_left     = 0;
        req_index     = 0;
        stall_count   = 0;
        for (int i = 0; i < NUM_NOTES; i++)
            model_stock[i] = '0;

        // empty stock: zero amount pays out nothing, anything else fails
        dir_table.push_back('{make_req(REQ_WITHDRAW, 0, all_counts(0)), 1'b1,
                              uniform_receipt(1'b1, 0, 0)});
        dir_table.push_back('{make_req(REQ_WITHDRAW, 1, all_counts(0)), 1'b1,
                              uniform_receipt(1'b0, 0, 0)});
        dir_table.push_back('{make_req(REQ_WITHDRAW, '1, all_counts(COUNT_FULL)), 1'b1,
                              uniform_receipt(1'b0, 0, 0)});
        // deposit ignores the amount
        dir_table.push_back('{make_req(REQ_DEPOSIT, '1, all_counts(0)), 1'b1,
                              uniform_receipt(1'b1, 0, 0)});
        dir_table.push_back('{make_req(REQ_DEPOSIT, 0, all_counts(1)), 1'b1,
                              uniform_receipt(1'b1, 0, 1)});
        dir_table.push_back('{make_req(REQ_WITHDRAW, 166, all_counts(0)), 1'b1,
                              uniform_receipt(1'b1, 1, 0)});
        dir_table.push_back('{make_req(REQ_WITHDRAW, 3, all_counts(0)), 1'b0, '0});
        dir_table.push_back('{make_req(REQ_DEPOSIT, 0, {16'd2, 16'd3, 16'd0, 16'd2, 16'd0}),
                              1'b0, '0});
        dir_table.push_back('{make_req(REQ_WITHDRAW, 60, all_counts(0)), 1'b0, '0});
        dir_table.push_back('{make_req(REQ_WITHDRAW, 7, all_counts(0)), 1'b0, '0});
        dir_table.push_back('{make_req(REQ_WITHDRAW, 4, all_counts(0)), 1'b0, '0});
        dir_table.push_back('{make_req(REQ_WITHDRAW, 50, all_counts(COUNT_FULL)), 1'b0, '0});
        dir_table.push_back('{make_req(REQ_WITHDRAW, 2, all_counts(0)), 1'b0, '0});
        // saturation on the way to a full store
        dir_table.push_back('{make_req(REQ_DEPOSIT, 0, all_counts(COUNT_FULL)), 1'b1,
                              uniform_receipt(1'b1, 0, COUNT_FULL)});
        dir_table.push_back('{make_req(REQ_DEPOSIT, '1, all_counts(1)), 1'b1,
                              uniform_receipt(1'b1, 0, COUNT_FULL)});
        dir_table.push_back('{make_req(REQ_WITHDRAW, '1, all_counts(COUNT_FULL)), 1'b0, '0});
        dir_table.push_back('{make_req(REQ_WITHDRAW, 1000000, all_counts(0)), 1'b0, '0});
        dir_table.push_back('{make_req(REQ_WITHDRAW, 6553500, all_counts(0)), 1'b0, '0});
        dir_table.push_back('{make_req(REQ_WITHDRAW, 12345, all_counts(0)), 1'b0, '0});
        dir_table.push_back('{make_req(REQ_DEPOSIT, 0, all_counts(COUNT_FULL)), 1'b0, '0});
        dir_table.push_back('{make_req(REQ_WITHDRAW, 9999999, all_counts(0)), 1'b0, '0});

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i])
            offer_request(dir_table[i].req, dir_table[i].typed, dir_table[i].res);
        repeat (RANDOM_ITEMS)
            offer_request(random_req(), 1'b0, '0);
        s_axis_tvalid <= 1'b0;

        while (due_receipts.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
